// ----- rtl/pngu_pkg.sv -----
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants, types and per-channel arithmetic for the PNG unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;

	localparam int unsigned PIX_W    = 32;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned NCHAN    = 4;
	localparam int unsigned FILT_W   = 8;
	localparam int unsigned WIDTH_W  = 13;
	localparam int unsigned HEIGHT_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	// wide enough for a count plus one up to 65536
	localparam int unsigned CNT_W    = 17;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// filter codes
	localparam logic [FILT_W-1:0] FILT_NONE  = 8'd0;
	localparam logic [FILT_W-1:0] FILT_SUB   = 8'd1;
	localparam logic [FILT_W-1:0] FILT_UP    = 8'd2;
	localparam logic [FILT_W-1:0] FILT_AVG   = 8'd3;
	localparam logic [FILT_W-1:0] FILT_PAETH = 8'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] upleft;
	} pngu_nb_t;

	typedef struct packed {
		logic [FILT_W-1:0] filter;
		logic              has_alpha;
	} pngu_ctl_t;

	function automatic logic [CHAN_W-1:0] paeth(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b,
		input logic [CHAN_W-1:0] c
	);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [CHAN_W-1:0] res;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = da + db;
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc)
			res = a;
		else if (pb <= pc)
			res = b;
		else
			res = c;
		return res;
	endfunction

	function automatic logic [CHAN_W-1:0] predict(
		input logic [FILT_W-1:0] filter,
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b,
		input logic [CHAN_W-1:0] c
	);
		logic [CHAN_W:0] sum;
		logic [CHAN_W-1:0] res;
		sum = {1'b0, a} + {1'b0, b};
		unique case (filter)
			FILT_SUB:   res = a;
			FILT_UP:    res = b;
			FILT_AVG:   res = sum[CHAN_W:1];
			FILT_PAETH: res = paeth(a, b, c);
			default:    res = '0;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/pngu_recon.sv -----
// ----------------------------------------------------------------------------
// pngu_recon
// Per-channel reconstruction of one RGBA pixel from its neighbors.
// ----------------------------------------------------------------------------
module pngu_recon import pngu_pkg::*; (
	input  logic [PIX_W-1:0] pix,
	input  pngu_nb_t         nb,
	input  pngu_ctl_t        ctl,
	output logic [PIX_W-1:0] recon
);

	always_comb begin
		for (int k = 0; k < NCHAN; k++) begin
			recon[k*CHAN_W +: CHAN_W] = pix[k*CHAN_W +: CHAN_W]
				+ predict(ctl.filter,
					nb.left[k*CHAN_W +: CHAN_W],
					nb.above[k*CHAN_W +: CHAN_W],
					nb.upleft[k*CHAN_W +: CHAN_W]);
		end
		if (!ctl.has_alpha)
			recon[(NCHAN-1)*CHAN_W +: CHAN_W] = ALPHA_OPAQUE;
	end

endmodule

// ----- rtl/png_scanline_unfilter.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (none, sub, up, average, Paeth) for 8-bit RGBA.
// ----------------------------------------------------------------------------
// Takes one pixel beat per cycle unless the output stalls, and delivers one
// reconstructed beat per pixel through the stage 1 and output registers. The
// previous row sits in a MAX_WIDTH x 32 line buffer: the entry above is read
// on the cycle a pixel is taken and written back with the result when it leaves
// stage 1; a one-pixel-wide image (back-to-back access to the same entry) is
// served by forwarding. An output register lets the next pixel in while a
// result waits. Throughput is one pixel per clock while the output is not stalled.
module png_scanline_unfilter import pngu_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in, alpha_in
	input  logic [FILT_W-1:0]     s_tuser,   // filter_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic                  m_tlast,   // row_end
	output logic                  m_tuser    // image_end
);

	localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic                has_alpha_q;

	logic [PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [XW-1:0]       x_q;
	logic [HEIGHT_W-1:0] y_q;
	logic [PIX_W-1:0]    left_q;
	logic [PIX_W-1:0]    upleft_q;

	logic                s1_valid_q;
	logic [PIX_W-1:0]    pix_s1;
	logic [FILT_W-1:0]   filt_s1;
	logic [XW-1:0]       x_s1;
	logic                x0_s1;
	logic                y0_s1;
	logic                row_end_s1;
	logic                img_end_s1;
	logic                fwd_s1;
	logic [PIX_W-1:0]    fwd_data_s1;
	logic [PIX_W-1:0]    rd_s1;

	logic                out_valid_q;
	logic [PIX_W-1:0]    out_data_q;
	logic                out_last_q;
	logic                out_end_q;

	logic                accept;
	logic                adv;
	logic [CNT_W-1:0]    width_lim;
	logic [CNT_W-1:0]    height_lim;
	logic [CNT_W-1:0]    x_next;
	logic [CNT_W-1:0]    y_next;
	logic                row_end;
	logic                img_end;
	logic [PIX_W-1:0]    above_raw;
	pngu_nb_t            nb;
	pngu_ctl_t           ctl;
	logic [PIX_W-1:0]    recon;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_W'(1);
			image_height_q <= HEIGHT_W'(1);
			has_alpha_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_HAS_ALPHA:    has_alpha_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv      = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;
	assign accept   = s_tvalid && s_tready;

	// position tracking
	always_comb begin
		if (image_width_q == '0)
			width_lim = CNT_W'(1);
		else if (CNT_W'(image_width_q) > CNT_W'(MAX_WIDTH))
			width_lim = CNT_W'(MAX_WIDTH);
		else
			width_lim = CNT_W'(image_width_q);
		height_lim = (image_height_q == '0) ? CNT_W'(1) : CNT_W'(image_height_q);
		x_next  = CNT_W'(x_q) + CNT_W'(1);
		y_next  = CNT_W'(y_q) + CNT_W'(1);
		row_end = x_next >= width_lim;
		img_end = row_end && (y_next >= height_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= img_end ? '0 : y_next[HEIGHT_W-1:0];
			end else begin
				x_q <= x_next[XW-1:0];
			end
		end
	end

	// line buffer
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[x_q];
		if (adv)
			line_mem[x_s1] <= recon;
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= accept || (s1_valid_q && !adv);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= s_tdata;
			filt_s1     <= s_tuser;
			x_s1        <= x_q;
			x0_s1       <= (x_q == '0);
			y0_s1       <= (y_q == '0);
			row_end_s1  <= row_end;
			img_end_s1  <= img_end;
			fwd_s1      <= adv && (x_s1 == x_q);
			fwd_data_s1 <= recon;
		end
	end

	assign above_raw  = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign nb.left    = x0_s1 ? '0 : left_q;
	assign nb.above   = y0_s1 ? '0 : above_raw;
	assign nb.upleft  = (x0_s1 || y0_s1) ? '0 : upleft_q;
	assign ctl.filter    = filt_s1;
	assign ctl.has_alpha = has_alpha_q;

	pngu_recon u_recon (
		.pix   (pix_s1),
		.nb    (nb),
		.ctl   (ctl),
		.recon (recon)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (adv) begin
			left_q   <= recon;
			upleft_q <= nb.above;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= recon;
			out_last_q <= row_end_s1;
			out_end_q  <= img_end_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_end_q;

endmodule

// ----- rtl/pngu_checker.sv -----
// ----------------------------------------------------------------------------
// pngu_checker
// Port-level checks for png_scanline_unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module pngu_checker import pngu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [PIX_W-1:0]  m_tdata,
	input logic              m_tlast,
	input logic              m_tuser
);

	// end of image is always end of a row
	a_img_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end without row end");

	// input only backs up when the output is stalled
	a_stall_only_on_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// an accepted pixel with a free output and no pixel ahead of it shows up at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && !$past(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("pixel not delivered");

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output beat changed while stalled");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
// Streams filtered RGBA pixel beats through the block and rebuilds every
// pixel in a local line-buffer model to predict data, row end and image end.
// A short directed table comes first: each filter and unknown filter codes
// on a fresh image, a 3x3 image without alpha, and width 0 read as 1. Random
// phases follow, each with new register settings (size extremes, alpha on
// and off, width and height changes in the middle of an image), then a
// stretch with the width register set beyond the line buffer size. Both
// sides idle at random; one phase has the receiver hold off long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_top;
	import pngu_pkg::*;

	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned HOLD_CYCLES   = 120;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned CLAMP_BEATS   = 64;
	localparam int unsigned N_DIR         = 21;
	localparam logic [FILT_W-1:0] FILT_FIRST_UNKNOWN = FILT_PAETH + 8'd1;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             row_end;
		logic             image_end;
	} pixel_result_t;

	typedef struct packed {
		logic                  reconf;
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		logic                  alpha;
		logic [FILT_W-1:0]     filt;
		logic [PIX_W-1:0]      pix;
		logic                  typed;
		logic [PIX_W-1:0]      exp_pix;
		logic                  exp_row_end;
		logic                  exp_image_end;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;
	logic [FILT_W-1:0]     s_tuser   = FILT_NONE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [PIX_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	// local image state
	bit   [PIX_W-1:0]      line_mem [MAX_WIDTH_DEF];
	bit                    line_written [MAX_WIDTH_DEF];
	int unsigned           written_prefix = 0;
	logic [PIX_W-1:0]      left_px   = '0;
	logic [PIX_W-1:0]      upleft_px = '0;
	int unsigned           col_idx   = 0;
	int unsigned           row_idx   = 0;
	logic [WIDTH_W-1:0]    cur_width  = 13'd1;
	logic [HEIGHT_W-1:0]   cur_height = 16'd1;
	logic                  cur_alpha  = 1'b1;

	pixel_result_t         pending_pixels [$];
	logic                  typed_on = 1'b0;
	pixel_result_t         typed_res = '0;
	logic [FILT_W-1:0]     row_filter = FILT_NONE;
	logic [CHAN_W-1:0]     corner_vals [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
	string                 chan_names [NCHAN] = '{"red_out", "green_out", "blue_out", "alpha_out"};

	bit                    calm = 1'b0;
	int unsigned           stall_asks = 0;
	int unsigned           stall_done = 0;
	int unsigned           hold_left  = 0;
	int unsigned           errors     = 0;
	int unsigned           checked    = 0;
	int unsigned           row_ends   = 0;
	int unsigned           image_ends = 0;
	int unsigned           settings_used = 1;
	int unsigned           idle_cycles   = 0;

	png_scanline_unfilter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // red_in, green_in, blue_in, alpha_in
		.s_tuser   (s_tuser),   // filter_type
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // red_out, green_out, blue_out, alpha_out
		.m_tlast   (m_tlast),   // row_end
		.m_tuser   (m_tuser)    // image_end
	);

	always #10 clk = ~clk;

	function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic logic [CHAN_W-1:0] paeth_pick(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b,
		input logic [CHAN_W-1:0] c
	);
		int p;
		int da;
		int db;
		int dc;
		p  = int'(a) + int'(b) - int'(c);
		da = p - int'(a);
		db = p - int'(b);
		dc = p - int'(c);
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc)
			return a;
		if (db <= dc)
			return b;
		return c;
	endfunction

	// rebuilds one pixel and advances the local image state
	function automatic pixel_result_t unfilter_pixel(
		input logic [FILT_W-1:0] f,
		input logic [PIX_W-1:0]  px
	);
		int unsigned       w;
		int unsigned       h;
		int                k;
		logic [PIX_W-1:0]  lft;
		logic [PIX_W-1:0]  abv;
		logic [PIX_W-1:0]  ul;
		logic [PIX_W-1:0]  rec;
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] c;
		logic [CHAN_W-1:0] pr;
		logic [CHAN_W:0]   sum;
		pixel_result_t     res;
		w   = eff_width(cur_width);
		h   = (cur_height == 0) ? 1 : cur_height;
		lft = (col_idx == 0) ? '0 : left_px;
		abv = (row_idx == 0) ? '0 : line_mem[col_idx];
		ul  = (col_idx == 0 || row_idx == 0) ? '0 : upleft_px;
		for (k = 0; k < NCHAN; k++) begin
			a   = lft[CHAN_W*k +: CHAN_W];
			b   = abv[CHAN_W*k +: CHAN_W];
			c   = ul[CHAN_W*k +: CHAN_W];
			sum = {1'b0, a} + {1'b0, b};
			unique case (f)
				FILT_SUB:   pr = a;
				FILT_UP:    pr = b;
				FILT_AVG:   pr = sum[CHAN_W:1];
				FILT_PAETH: pr = paeth_pick(a, b, c);
				default:    pr = '0;
			endcase
			rec[CHAN_W*k +: CHAN_W] = px[CHAN_W*k +: CHAN_W] + pr;
		end
		if (!cur_alpha)
			rec[PIX_W-1 -: CHAN_W] = ALPHA_OPAQUE;
		line_mem[col_idx]     = rec;
		line_written[col_idx] = 1'b1;
		while (written_prefix < MAX_WIDTH_DEF && line_written[written_prefix])
			written_prefix++;
		left_px       = rec;
		upleft_px     = abv;
		res.pix       = rec;
		res.row_end   = (col_idx + 1 >= w);
		res.image_end = res.row_end && (row_idx + 1 >= h);
		if (res.row_end) begin
			col_idx = 0;
			row_idx = res.image_end ? 0 : row_idx + 1;
		end else begin
			col_idx++;
		end
		return res;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic push_pixel(input logic [FILT_W-1:0] f, input logic [PIX_W-1:0] px);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(
		input logic [CFG_DATA_W-1:0] w,
		input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_DATA_W-1:0] a
	);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_index <= CFG_HAS_ALPHA;
		cfg_data  <= a;
		@(negedge clk);
		cfg_we     <= 1'b0;
		cur_width  = w[WIDTH_W-1:0];
		cur_height = h;
		cur_alpha  = a[0];
		settings_used++;
	endtask

	// mostly one filter per row, with some per-pixel changes and corner values
	task automatic send_random(input int unsigned count);
		int unsigned      i;
		int               k;
		logic [PIX_W-1:0] px;
		for (i = 0; i < count; i++) begin
			if (col_idx == 0 || $urandom_range(99) < 20)
				row_filter = ($urandom_range(99) < 88) ? FILT_W'($urandom_range(FILT_PAETH))
					: FILT_W'($urandom_range(255, FILT_FIRST_UNKNOWN));
			for (k = 0; k < NCHAN; k++)
				px[CHAN_W*k +: CHAN_W] = ($urandom_range(3) == 0)
					? corner_vals[$urandom_range(5)] : CHAN_W'($urandom_range(255));
			push_pixel(row_filter, px);
		end
	endtask

	// receiver: random idling, long hold-offs on request
	always @(negedge clk) begin
		if (stall_asks != stall_done) begin
			stall_done = stall_asks;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin : check_beats
		pixel_result_t pred;
		pixel_result_t want;
		int            k;
		if (arst_n && s_tvalid && s_tready) begin
			pred = unfilter_pixel(s_tuser, s_tdata);
			if (pred.row_end)
				row_ends++;
			if (pred.image_end)
				image_ends++;
			pending_pixels.push_back(typed_on ? typed_res : pred);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected output beat, data %h", m_tdata);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				checked++;
				for (k = 0; k < NCHAN; k++)
					if (m_tdata[CHAN_W*k +: CHAN_W] !== want.pix[CHAN_W*k +: CHAN_W]) begin
						$error("%s: expected %0d, got %0d", chan_names[k],
							want.pix[CHAN_W*k +: CHAN_W], m_tdata[CHAN_W*k +: CHAN_W]);
						errors++;
					end
				if (m_tlast !== want.row_end) begin
					$error("row_end: expected %0d, got %0d", want.row_end, m_tlast);
					errors++;
				end
				if (m_tuser !== want.image_end) begin
					$error("image_end: expected %0d, got %0d", want.image_end, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("png_scanline_unfilter: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned           p;
		int unsigned           r;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		dir_row_t              row;
		dir_row_t              dir_rows [N_DIR];
		// reconf, width, height, alpha, filter, pixel, typed, exp pixel, row end, image end
		dir_rows = '{
			// reset settings: 1x1 images, every neighbor is zero
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_NONE, 32'h00000000, 1'b1, 32'h00000000, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_SUB, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_UP, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_AVG, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_PAETH, 32'h80808080, 1'b1, 32'h80808080, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_FIRST_UNKNOWN, 32'h01234567, 1'b1, 32'h01234567,
				1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, 8'hFF, 32'h89ABCDEF, 1'b1, 32'h89ABCDEF, 1'b1, 1'b1},
			'{1'b0, 16'd0, 16'd0, 1'b0, 8'hAA, 32'h7F7F7F7F, 1'b1, 32'h7F7F7F7F, 1'b1, 1'b1},
			// 3x3 without alpha
			'{1'b1, 16'd3, 16'd3, 1'b0, FILT_NONE, 32'h40302010, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_SUB, 32'hF0F0F0F0, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_PAETH, 32'h7F80FE01, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_UP, 32'h00FF00FF, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_AVG, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_PAETH, 32'h01020304, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_PAETH, 32'h80808080, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, 8'hFF, 32'hDEADBEEF, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_FIRST_UNKNOWN, 32'h00000000, 1'b0, 32'h0, 1'b0, 1'b0},
			// width 0 acts as 1, two rows per image
			'{1'b1, 16'd0, 16'd2, 1'b1, FILT_UP, 32'h11223344, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_PAETH, 32'hF0E0D0C0, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_AVG, 32'h01FF01FF, 1'b0, 32'h0, 1'b0, 1'b0},
			'{1'b0, 16'd0, 16'd0, 1'b0, FILT_UP, 32'hFEFEFEFE, 1'b0, 32'h0, 1'b0, 1'b0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.reconf) begin
				drain_results();
				apply_settings(row.width, row.height, {15'd0, row.alpha});
			end
			typed_on  = row.typed;
			typed_res = {row.exp_pix, row.exp_row_end, row.exp_image_end};
			push_pixel(row.filt, row.pix);
		end
		typed_on = 1'b0;

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			r = $urandom_range(99);
			if (r < 70)
				w = CFG_DATA_W'($urandom_range(6, 1));
			else if (r < 85)
				w = CFG_DATA_W'($urandom_range(24, 7));
			else if (r < 90)
				w = '0;
			else if (r < 98)
				w = CFG_DATA_W'($urandom_range(64, 25));
			else
				w = CFG_DATA_W'(MAX_WIDTH_DEF);
			// never widen past what the line buffer already holds mid-image
			if (row_idx != 0 && eff_width(w[WIDTH_W-1:0]) > written_prefix)
				w = CFG_DATA_W'(written_prefix);
			r = $urandom_range(99);
			if (r < 60)
				h = CFG_DATA_W'($urandom_range(4, 1));
			else if (r < 80)
				h = '0;
			else if (r < 90)
				h = 16'hFFFF;
			else
				h = CFG_DATA_W'($urandom_range(10, 5));
			apply_settings(w, h, CFG_DATA_W'($urandom_range(1)));
			calm = (p == 6);
			if (p == 3)
				stall_asks++;
			send_random($urandom_range(70, 30));
		end
		calm = 1'b0;

		// close the open image, then a stretch with the width above the buffer size
		drain_results();
		apply_settings({3'd0, cur_width}, 16'd0, {15'd0, cur_alpha});
		while (col_idx != 0 || row_idx != 0)
			send_random(1);
		drain_results();
		apply_settings(16'd8191, 16'd0, CFG_DATA_W'($urandom_range(1)));
		send_random(CLAMP_BEATS);
		drain_results();

		$display("%0d pixel beats checked under %0d register settings, width clamp included",
			checked, settings_used);
		$display("%0d row ends, %0d image ends; all filters, no-alpha and receiver backpressure",
			row_ends, image_ends);
		if (errors == 0)
			$display("png_scanline_unfilter: match");
		else
			$display("png_scanline_unfilter: mismatch");
		$finish;
	end

endmodule
